// File: sv/reid_gallery_matcher_core_assert.svh
// Assertion macros used by the matcher checker.
`ifndef REID_GALLERY_MATCHER_CORE_ASSERT_SVH
`define REID_GALLERY_MATCHER_CORE_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define RGM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define RGM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rgm_pkg.sv
// Shared types and constants of the re-identification gallery matcher.
package rgm_pkg;

	localparam int MAX_PERSONS_DEF = 64;
	localparam int DESC_LEN_DEF    = 256;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_THRESHOLD = 1'b0,
		REG_MISS_LIMIT      = 1'b1
	} reg_idx_t;

	localparam logic signed [15:0] THRESHOLD_RESET  = 16'sd13107;
	localparam logic [7:0]         MISS_LIMIT_RESET = 8'd50;
	localparam logic [7:0]         MISS_SAT         = 8'd255;

	localparam logic CMD_ELEM = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	localparam logic signed [15:0] SIM_NEW = 16'sh7fff;
	localparam logic signed [15:0] SIM_MIN = 16'sh8000;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] elem_value;
		logic               last_elem;
		logic [15:0]        box_x;
		logic [15:0]        box_y;
		logic [15:0]        box_w;
		logic [15:0]        box_h;
	} obj_t;

	typedef struct packed {
		logic [31:0]        object_id;
		logic signed [15:0] similarity;
		logic               is_new;
		logic               not_stored;
	} res_t;

endpackage

// File: sv/rgm_if.sv
// Valid/ready channel interfaces for object items and match results.
interface rgm_obj_if;
	import rgm_pkg::*;
	logic valid;
	logic ready;
	obj_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rgm_res_if;
	import rgm_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/rgm_sqrt.sv
// Iterative integer square root, two operand bits per cycle.
module rgm_sqrt #(
	parameter int SQ_W = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [SQ_W-1:0]         operand,
	output logic                    done,
	output logic [(SQ_W+1)/2-1:0]   root
);
	localparam int RT_W  = (SQ_W + 1) / 2;
	localparam int OP_W  = 2 * RT_W;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [OP_W-1:0]  op_q;
	logic [RT_W:0]    rem_q;
	logic [RT_W-1:0]  root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [RT_W+2:0]  rem_sh;
	logic [RT_W+2:0]  trial;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, op_q[OP_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(RT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= OP_W'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			op_q   <= {op_q[OP_W-3:0], 2'b00};
			rem_q  <= ge ? (RT_W+1)'(rem_sh - trial) : rem_sh[RT_W:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: sv/rgm_div.sv
// Restoring divider, one quotient bit per cycle.
module rgm_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// File: sv/reid_gallery_matcher_core.sv
// Gallery matcher top: cosine nearest neighbor over stored descriptors.
// Element items: one per cycle while idle; a last element holds the input while the query
//   norm root runs and then, for each valid entry, a walk, root, divide and compare, and
//   then the update pass and result, on the shared square root, divider and one memory port.
// The update pass is skipped on a full gallery and the divide on a zero norm; results may stall.
// End of frame: all entries age at once. Reset: all entry flags clear at once, no sweep.
module reid_gallery_matcher_core #(
	parameter int MAX_PERSONS = rgm_pkg::MAX_PERSONS_DEF,
	parameter int DESC_LEN    = rgm_pkg::DESC_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rgm_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
	input  logic [rgm_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	rgm_obj_if.sink                        obj,
	rgm_res_if.source                      res
);
	import rgm_pkg::*;

	localparam int KI_W  = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
	localparam int KC_W  = $clog2(MAX_PERSONS + 1);
	localparam int DI_W  = $clog2(DESC_LEN);
	localparam int DC_W  = $clog2(DESC_LEN + 1);
	localparam int GA_W  = (MAX_PERSONS * DESC_LEN > 1) ? $clog2(MAX_PERSONS * DESC_LEN) : 1;
	localparam int ACC_W = 32 + $clog2(DESC_LEN);
	localparam int RT_W  = (ACC_W + 1) / 2;
	localparam int DEN_W = 2 * RT_W;
	localparam int NUM_W = ACC_W + 15;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_QGO    = 14'b00000000000010,
		S_QWAIT  = 14'b00000000000100,
		S_ENT    = 14'b00000000001000,
		S_WALK   = 14'b00000000010000,
		S_GGO    = 14'b00000000100000,
		S_GWAIT  = 14'b00000001000000,
		S_DIVGO  = 14'b00000010000000,
		S_DIV    = 14'b00000100000000,
		S_CMP    = 14'b00001000000000,
		S_DECIDE = 14'b00010000000000,
		S_UPD    = 14'b00100000000000,
		S_OUT    = 14'b01000000000000,
		S_SPARE  = 14'b10000000000000
	} state_t;

	function automatic logic [15:0] blend_u16(input logic [15:0] o, input logic [15:0] n);
		logic [17:0] s;
		s = {2'b00, o} + {1'b0, o, 1'b0} + {2'b00, n};
		return s[17:2];
	endfunction

	// Configuration registers
	logic signed [15:0] thr_q;
	logic [7:0]         limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RESET;
			limit_q <= MISS_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_wr_idx))
				REG_MATCH_THRESHOLD: thr_q   <= $signed(cfg_wr_data[15:0]);
				REG_MISS_LIMIT:      limit_q <= cfg_wr_data[7:0];
				default:             ;
			endcase
		end
	end

	// Control state
	state_t             state_q;
	logic [DC_W-1:0]    cnt_q;
	logic [DC_W-1:0]    qlen_q;
	logic [ACC_W-1:0]   qn_q;
	logic [63:0]        box_q;
	logic [RT_W-1:0]    qroot_q;
	logic [KC_W-1:0]    k_q;
	logic [GA_W-1:0]    base_q;
	logic [DI_W-1:0]    idx_q;
	logic               issuing_q;
	logic               copy_q;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0]   gn_q;
	logic [DEN_W-1:0]   den_q;
	logic signed [15:0] sim_q;
	logic               best_found_q;
	logic signed [15:0] best_sim_q;
	logic [KI_W-1:0]    best_k_q;
	logic [31:0]        best_id_q;
	logic               free_found_q;
	logic [KI_W-1:0]    free_q;
	logic [31:0]        next_id_q;
	logic               res_v_q;
	res_t               res_q;
	res_t               pend_q;

	// Entry flags, cleared at reset
	logic               valid_q [MAX_PERSONS];
	logic               hit_q   [MAX_PERSONS];
	logic [7:0]         miss_q  [MAX_PERSONS];

	// Memories
	logic signed [15:0] qmem  [DESC_LEN];
	logic signed [15:0] gmem  [MAX_PERSONS * DESC_LEN];
	logic [31:0]        idmem [MAX_PERSONS];
	logic [63:0]        boxmem[MAX_PERSONS];
	logic [31:0]        id_rd_q;
	logic [63:0]        box_rd_q;

	// Walk pipeline
	logic signed [15:0] qrd_s1, grd_s1;
	logic               v_s1, z_s1;
	logic [GA_W-1:0]    ga_s1;
	logic signed [31:0] pq_s2, pg_s2;
	logic               v_s2;

	logic               elem_acc, eof_acc, take;
	logic signed [31:0] sq_in;
	logic [KI_W-1:0]    k_idx;
	logic [GA_W-1:0]    ga;
	logic signed [15:0] qval_s1;
	logic signed [17:0] bl_sum;
	logic signed [17:0] bl_adj;
	logic signed [15:0] bl_val;
	logic               sq_start, sq_done, dv_done;
	logic [RT_W-1:0]    sq_root;
	logic [NUM_W-1:0]   dv_quot;
	logic [ACC_W-1:0]   mag;
	logic signed [15:0] sim_sat;
	logic               better, match;

	assign obj.ready = (state_q == S_IDLE);
	assign elem_acc  = obj.valid && obj.ready && (obj.data.cmd == CMD_ELEM);
	assign eof_acc   = obj.valid && obj.ready && (obj.data.cmd == CMD_EOF);
	assign take      = elem_acc && (cnt_q < DC_W'(DESC_LEN));
	assign sq_in     = obj.data.elem_value * obj.data.elem_value;
	assign k_idx     = k_q[KI_W-1:0];
	assign ga        = base_q + GA_W'(idx_q);
	assign qval_s1   = z_s1 ? 16'sd0 : qrd_s1;

	// Blend 3/4 old plus 1/4 new, rounding toward zero
	always_comb begin
		bl_sum = {{2{grd_s1[15]}}, grd_s1} + {grd_s1[15], grd_s1, 1'b0}
			+ {{2{qval_s1[15]}}, qval_s1};
		bl_adj = bl_sum + (bl_sum[17] ? 18'sd3 : 18'sd0);
		bl_val = bl_adj[17:2];
	end

	assign mag = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);

	always_comb begin
		if (dot_q[ACC_W-1]) begin
			sim_sat = (dv_quot > NUM_W'(32768)) ? SIM_MIN : $signed(~dv_quot[15:0] + 16'd1);
		end else begin
			sim_sat = (dv_quot > NUM_W'(32767)) ? SIM_NEW : $signed(dv_quot[15:0]);
		end
	end

	assign better = (sim_q > best_sim_q) ||
		(best_found_q && (sim_q == best_sim_q) && (id_rd_q < best_id_q));
	assign match  = best_found_q && (best_sim_q > thr_q);

	assign sq_start = (state_q == S_QGO) || (state_q == S_GGO);

	rgm_sqrt #(.SQ_W(ACC_W)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand ((state_q == S_QGO) ? qn_q : gn_q),
		.done    (sq_done),
		.root    (sq_root)
	);

	rgm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == S_DIVGO) && (den_q != '0)),
		.dividend (NUM_W'(mag) << 15),
		.divisor  (den_q),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			qn_q         <= '0;
			issuing_q    <= 1'b0;
			next_id_q    <= '0;
			res_v_q      <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			k_q          <= '0;
		end else begin
			if (res.ready && (state_q != S_OUT)) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (eof_acc) begin
						cnt_q <= '0;
						qn_q  <= '0;
					end else if (take) begin
						cnt_q <= cnt_q + 1'b1;
						qn_q  <= qn_q + ACC_W'($unsigned(sq_in));
					end
					if (elem_acc && obj.data.last_elem) begin
						qlen_q  <= take ? DC_W'(cnt_q + 1'b1) : cnt_q;
						box_q   <= {obj.data.box_h, obj.data.box_w, obj.data.box_y,
							obj.data.box_x};
						state_q <= S_QGO;
					end
				end
				S_QGO: begin
					cnt_q   <= '0;
					qn_q    <= '0;
					state_q <= S_QWAIT;
				end
				S_QWAIT: begin
					if (sq_done) begin
						qroot_q      <= sq_root;
						k_q          <= '0;
						best_found_q <= 1'b0;
						best_sim_q   <= SIM_MIN;
						free_found_q <= 1'b0;
						state_q      <= S_ENT;
					end
				end
				S_ENT: begin
					if (k_q == KC_W'(MAX_PERSONS)) begin
						state_q <= S_DECIDE;
					end else if (!valid_q[k_idx]) begin
						if (!free_found_q) begin
							free_q       <= k_idx;
							free_found_q <= 1'b1;
						end
						k_q <= k_q + 1'b1;
					end else begin
						base_q    <= GA_W'(k_idx * DESC_LEN);
						idx_q     <= '0;
						issuing_q <= 1'b1;
						dot_q     <= '0;
						gn_q      <= '0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					if (issuing_q) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == DI_W'(DESC_LEN - 1)) begin
							issuing_q <= 1'b0;
						end
					end
					if (v_s2) begin
						dot_q <= dot_q + ACC_W'(pq_s2);
						gn_q  <= gn_q + ACC_W'($unsigned(pg_s2));
					end
					if (!issuing_q && !v_s1 && !v_s2) begin
						state_q <= S_GGO;
					end
				end
				S_GGO: begin
					state_q <= S_GWAIT;
				end
				S_GWAIT: begin
					if (sq_done) begin
						den_q   <= DEN_W'(qroot_q) * DEN_W'(sq_root);
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: begin
					if (den_q == '0) begin
						sim_q   <= 16'sd0;
						state_q <= S_CMP;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dv_done) begin
						sim_q   <= sim_sat;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (better) begin
						best_sim_q   <= sim_q;
						best_k_q     <= k_idx;
						best_id_q    <= id_rd_q;
						best_found_q <= 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= S_ENT;
				end
				S_DECIDE: begin
					idx_q <= '0;
					if (match) begin
						pend_q    <= '{object_id: best_id_q, similarity: best_sim_q,
							is_new: 1'b0, not_stored: 1'b0};
						base_q    <= GA_W'(best_k_q * DESC_LEN);
						copy_q    <= 1'b0;
						issuing_q <= 1'b1;
						state_q   <= S_UPD;
					end else begin
						next_id_q <= next_id_q + 1'b1;
						pend_q    <= '{object_id: next_id_q, similarity: SIM_NEW,
							is_new: 1'b1, not_stored: !free_found_q};
						if (free_found_q) begin
							base_q    <= GA_W'(free_q * DESC_LEN);
							copy_q    <= 1'b1;
							issuing_q <= 1'b1;
							state_q   <= S_UPD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_UPD: begin
					if (issuing_q) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == DI_W'(DESC_LEN - 1)) begin
							issuing_q <= 1'b0;
						end
					end
					if (!issuing_q && !v_s1) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the result register is free
					if (!res_v_q || res.ready) begin
						res_q   <= pend_q;
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Entry flags: frame-end aging of all entries at once, set on store or hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PERSONS; k++) begin
				valid_q[k] <= 1'b0;
				hit_q[k]   <= 1'b0;
				miss_q[k]  <= '0;
			end
		end else if (eof_acc) begin
			for (int k = 0; k < MAX_PERSONS; k++) begin
				if (valid_q[k]) begin
					logic [7:0] m;
					m = (!hit_q[k] && (miss_q[k] != MISS_SAT)) ? miss_q[k] + 8'd1 : miss_q[k];
					miss_q[k] <= m;
					hit_q[k]  <= 1'b0;
					if (m > limit_q) begin
						valid_q[k] <= 1'b0;
					end
				end
			end
		end else if (state_q == S_DECIDE) begin
			if (match) begin
				hit_q[best_k_q] <= 1'b1;
			end else if (free_found_q) begin
				valid_q[free_q] <= 1'b1;
				hit_q[free_q]   <= 1'b1;
				miss_q[free_q]  <= '0;
			end
		end
	end

	// Query store
	always_ff @(posedge clk) begin
		if (take) begin
			qmem[cnt_q[DI_W-1:0]] <= obj.data.elem_value;
		end
		qrd_s1 <= qmem[idx_q];
	end

	// Gallery vector store
	always_ff @(posedge clk) begin
		if (v_s1 && (state_q == S_UPD)) begin
			gmem[ga_s1] <= copy_q ? qval_s1 : bl_val;
		end
		grd_s1 <= gmem[ga];
	end

	// Identity and box stores
	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && !match && free_found_q) begin
			idmem[free_q] <= next_id_q;
		end
		id_rd_q <= idmem[k_idx];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && !match && free_found_q) begin
			boxmem[free_q] <= box_q;
		end else if ((state_q == S_UPD) && !copy_q && !issuing_q && !v_s1) begin
			boxmem[best_k_q] <= {blend_u16(box_rd_q[63:48], box_q[63:48]),
				blend_u16(box_rd_q[47:32], box_q[47:32]),
				blend_u16(box_rd_q[31:16], box_q[31:16]),
				blend_u16(box_rd_q[15:0], box_q[15:0])};
		end
		box_rd_q <= boxmem[best_k_q];
	end

	// Walk pipeline: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issuing_q && ((state_q == S_WALK) || (state_q == S_UPD));
			v_s2 <= v_s1 && (state_q == S_WALK);
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= (DC_W'(idx_q) >= qlen_q);
		ga_s1 <= ga;
		pq_s2 <= qval_s1 * grd_s1;
		pg_s2 <= grd_s1 * grd_s1;
	end

	assign res.valid = res_v_q;
	assign res.data  = res_q;

endmodule

// File: sv/rgm_checker.sv
// Port-level checker for the gallery matcher, bound to the top level.
`include "reid_gallery_matcher_core_assert.svh"

module rgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        obj_valid,
	input logic        obj_ready,
	input logic        obj_cmd,
	input logic        obj_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_object_id,
	input logic [15:0] res_similarity,
	input logic        res_is_new,
	input logic        res_not_stored
);
	import rgm_pkg::*;

	`RGM_ASSERT_ALWAYS(a_not_stored_new, (res_valid && res_not_stored) |-> res_is_new, "not_stored without is_new")
	`RGM_ASSERT_ALWAYS(a_new_sim, (res_valid && res_is_new) |-> (res_similarity == SIM_NEW), "new identity with wrong similarity")
	`RGM_ASSERT_NEXT(a_busy_after_last, obj_valid && obj_ready && (obj_cmd == CMD_ELEM) && obj_last, !obj_ready, "ready right after a last element")
	`RGM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_object_id), "stalled result changed")

endmodule

bind reid_gallery_matcher_core rgm_checker u_rgm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.obj_valid      (obj.valid),
	.obj_ready      (obj.ready),
	.obj_cmd        (obj.data.cmd),
	.obj_last       (obj.data.last_elem),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_object_id  (res.data.object_id),
	.res_similarity (res.data.similarity),
	.res_is_new     (res.data.is_new),
	.res_not_stored (res.data.not_stored)
);

// File: test/tb_rgm_pkg_note.sv
`timescale 1ns / 100ps
// Shared testbench settings for the gallery matcher bench.
package tb_rgm_cfg_pkg;
	localparam int NUM_PROTOS   = 6;
	localparam int DRAIN_CYCLES = 20;
	localparam longint CYCLE_LIMIT = 64'd150000000;
endpackage

// File: test/tb_reid_gallery_matcher_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the gallery matcher: queued driver, monitor, cosine predictor.
module tb_reid_gallery_matcher_core;
	import rgm_pkg::*;
	import tb_rgm_cfg_pkg::*;

	localparam int NP = MAX_PERSONS_DEF;
	localparam int DL = DESC_LEN_DEF;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_wr_idx;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	rgm_obj_if obj_ch();
	rgm_res_if res_ch();

	reid_gallery_matcher_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_idx(cfg_wr_idx),
		.cfg_wr_data(cfg_wr_data),
		.obj(obj_ch),
		.res(res_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mirror of the block's gallery, kept in step at every accepted transfer.
	logic signed [15:0] gal_thresh;
	logic [7:0]         gal_miss_limit;
	int                 qvec [DL];
	int                 gvec [NP][DL];
	bit                 ent_valid [NP];
	logic [31:0]        ent_ident [NP];
	logic [15:0]        ent_box [NP][4];
	bit                 ent_hit [NP];
	logic [7:0]         ent_misses [NP];
	logic [31:0]        next_id;
	int                 elem_cnt;

	obj_t pending_items[$];
	res_t expected_res[$];

	int n_err, n_res, n_new, n_unstored, n_match, n_evict, n_accepted;
	bit quiet;

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int cosine_q15(int k, longint unsigned qroot);
		longint dot;
		longint unsigned gn, den, mag, q;
		dot = 0;
		gn = 0;
		for (int i = 0; i < DL; i++) begin
			dot += longint'(qvec[i]) * longint'(gvec[k][i]);
			gn += longint'(gvec[k][i]) * longint'(gvec[k][i]);
		end
		den = qroot * root64(gn);
		if (den == 0) return 0;
		mag = (dot < 0) ? -dot : dot;
		q = (mag << 15) / den;
		if (dot < 0) return (q > 32768) ? -32768 : -int'(q);
		return (q > 32767) ? 32767 : int'(q);
	endfunction

	// Advance the gallery mirror by one transfer; queue the match result it causes.
	function automatic void gallery_step(obj_t it);
		int best, freeslot, best_sim, sim;
		longint unsigned qn, qroot;
		logic [15:0] nb [4];
		res_t r;
		best = -1;
		freeslot = -1;
		best_sim = -32768;
		qn = 0;
		if (it.cmd == CMD_EOF) begin
			// Age unhit entries, drop stale ones, discard any partial object.
			for (int k = 0; k < NP; k++) begin
				if (!ent_valid[k]) continue;
				if (!ent_hit[k] && ent_misses[k] < MISS_SAT) ent_misses[k]++;
				ent_hit[k] = 0;
				if (ent_misses[k] > gal_miss_limit) begin
					ent_valid[k] = 0;
					n_evict++;
				end
			end
			elem_cnt = 0;
			return;
		end
		if (elem_cnt < DL) begin
			qvec[elem_cnt] = it.elem_value;
			elem_cnt++;
		end
		if (!it.last_elem) return;
		for (int i = elem_cnt; i < DL; i++) qvec[i] = 0;
		elem_cnt = 0;
		nb = '{it.box_x, it.box_y, it.box_w, it.box_h};
		for (int i = 0; i < DL; i++) qn += longint'(qvec[i]) * longint'(qvec[i]);
		qroot = root64(qn);
		for (int k = 0; k < NP; k++) begin
			if (!ent_valid[k]) begin
				if (freeslot < 0) freeslot = k;
				continue;
			end
			sim = cosine_q15(k, qroot);
			if (sim > best_sim ||
			    (best >= 0 && sim == best_sim && ent_ident[k] < ent_ident[best])) begin
				best_sim = sim;
				best = k;
			end
		end
		r.not_stored = 1'b0;
		if (best >= 0 && best_sim > int'(gal_thresh)) begin
			// Blend 3/4 old with 1/4 new, truncating toward zero.
			r.object_id = ent_ident[best];
			for (int i = 0; i < DL; i++) gvec[best][i] = (gvec[best][i] * 3 + qvec[i]) / 4;
			for (int j = 0; j < 4; j++)
				ent_box[best][j] = 16'((32'(ent_box[best][j]) * 3 + 32'(nb[j])) / 4);
			ent_hit[best] = 1;
			r.similarity = 16'(best_sim);
			r.is_new = 1'b0;
			n_match++;
		end else begin
			r.object_id = next_id;
			next_id = next_id + 1;
			r.is_new = 1'b1;
			r.similarity = SIM_NEW;
			n_new++;
			if (freeslot >= 0) begin
				for (int i = 0; i < DL; i++) gvec[freeslot][i] = qvec[i];
				ent_valid[freeslot] = 1;
				ent_ident[freeslot] = r.object_id;
				ent_box[freeslot] = nb;
				ent_hit[freeslot] = 1;
				ent_misses[freeslot] = 0;
			end else begin
				r.not_stored = 1'b1;
				n_unstored++;
			end
		end
		expected_res = {expected_res, r};
	endfunction

	// Driver: present queued items, inserting random idle bursts between transfers.
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_ch.valid <= 1'b0;
			obj_ch.data <= '0;
			in_gap = 0;
		end else begin
			if (obj_ch.valid && obj_ch.ready) begin
				gallery_step(obj_ch.data);
				n_accepted++;
			end
			if (obj_ch.valid && !obj_ch.ready) begin
				// hold the item until the block takes it
			end else if (in_gap > 0) begin
				in_gap--;
				obj_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				in_gap = $urandom_range(0, 18);
				obj_ch.valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				obj_ch.data <= pending_items.pop_front();
				obj_ch.valid <= 1'b1;
			end else begin
				obj_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: stall the result side in bursts and compare every transfer.
	int out_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				n_res++;
				if (expected_res.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: id %0d sim %0d new %0b ns %0b",
							res_ch.data.object_id, res_ch.data.similarity,
							res_ch.data.is_new, res_ch.data.not_stored);
				end else begin
					res_t e;
					e = expected_res.pop_front();
					if (e !== res_ch.data) begin
						n_err++;
						if (n_err <= 10)
							$display({"result mismatch: expected id %0d sim %0d new %0b ns %0b,",
								" got id %0d sim %0d new %0b ns %0b"},
								e.object_id, e.similarity, e.is_new, e.not_stored,
								res_ch.data.object_id, res_ch.data.similarity,
								res_ch.data.is_new, res_ch.data.not_stored);
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall = $urandom_range(0, 18);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	longint cycles;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_reid_gallery_matcher_core: errors");
			$finish;
		end
	end

	function automatic obj_t elem_item(logic signed [15:0] v, bit last);
		obj_t it;
		it.cmd = CMD_ELEM;
		it.elem_value = v;
		it.last_elem = last;
		it.box_x = 16'($urandom);
		it.box_y = 16'($urandom);
		it.box_w = 16'($urandom);
		it.box_h = 16'($urandom);
		return it;
	endfunction

	function automatic obj_t eof_item();
		obj_t it;
		it = elem_item(16'($urandom), 1'($urandom_range(0, 1)));
		it.cmd = CMD_EOF;
		return it;
	endfunction

	// Queue a whole object of random content and the given length.
	task automatic push_noise(int len);
		for (int i = 0; i < len; i++)
			pending_items = {pending_items, elem_item(16'($urandom), i == len - 1)};
	endtask

	// Wait until everything queued is taken and answered, then let the block settle.
	task automatic drain();
		while (pending_items.size() != 0 || obj_ch.valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_idx <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_MATCH_THRESHOLD) gal_thresh = val;
		else gal_miss_limit = val[7:0];
	endtask

	// Prototype identities: objects re-present them with small noise so they match.
	logic signed [15:0] proto_vec [NUM_PROTOS][16];
	int                 proto_len [NUM_PROTOS];
	logic [15:0]        proto_box [NUM_PROTOS][4];

	task automatic push_proto(int p, bit cut_short);
		int len, v;
		obj_t it;
		len = cut_short ? $urandom_range(1, proto_len[p]) : proto_len[p];
		for (int i = 0; i < len; i++) begin
			v = int'(proto_vec[p][i]) + $urandom_range(0, 256) - 128;
			v = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
			it = elem_item(16'(v), i == len - 1);
			it.box_x = proto_box[p][0] + 16'($urandom_range(0, 7));
			it.box_y = proto_box[p][1] + 16'($urandom_range(0, 7));
			it.box_w = proto_box[p][2] + 16'($urandom_range(0, 7));
			it.box_h = proto_box[p][3] + 16'($urandom_range(0, 7));
			pending_items = {pending_items, it};
		end
	endtask

	task automatic run_random(int n_items, bit with_long);
		int start, r;
		start = n_accepted + pending_items.size();
		for (int p = 0; p < NUM_PROTOS; p++) begin
			proto_len[p] = $urandom_range(2, 16);
			for (int i = 0; i < 16; i++) proto_vec[p][i] = 16'($urandom);
			for (int j = 0; j < 4; j++) proto_box[p][j] = 16'($urandom);
		end
		// One object longer than the descriptor: the excess is dropped.
		if (with_long) push_noise(DL + 3);
		while (n_accepted + pending_items.size() - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 8) pending_items = {pending_items, eof_item()};
			else if (r < 12) push_noise($urandom_range(1, 8));
			else if (r < 15) begin
				// partial object cut off by end of frame
				push_noise($urandom_range(1, 5));
				void'(pending_items.pop_back());
				pending_items = {pending_items, eof_item()};
			end else push_proto($urandom_range(0, NUM_PROTOS - 1), r < 20);
			// keep the queue short so predictions stay close to stimulus
			while (pending_items.size() > 64) @(posedge clk);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_idx = '0;
		cfg_wr_data = '0;
		quiet = 0;
		n_err = 0; n_res = 0; n_new = 0; n_unstored = 0; n_match = 0;
		n_evict = 0; n_accepted = 0; cycles = 0;
		gal_thresh = THRESHOLD_RESET;
		gal_miss_limit = MISS_LIMIT_RESET;
		next_id = 0;
		elem_cnt = 0;
		for (int k = 0; k < NP; k++) begin
			ent_valid[k] = 0;
			ent_hit[k] = 0;
			ent_misses[k] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero vector, repeat match, partial object at frame end.
		pending_items = {pending_items, elem_item(16'sh7fff, 1)};
		pending_items = {pending_items, elem_item(16'sh7fff, 1)};
		pending_items = {pending_items, elem_item(16'sh8000, 1)};
		pending_items = {pending_items, elem_item(16'sh0000, 1)};
		pending_items = {pending_items, elem_item(16'sh8000, 0)};
		pending_items = {pending_items, elem_item(16'sh7fff, 1)};
		pending_items = {pending_items, elem_item(16'sh8000, 0)};
		pending_items = {pending_items, elem_item(16'sh7fff, 1)};
		pending_items = {pending_items, elem_item(16'sh1234, 0)};
		pending_items = {pending_items, eof_item()};
		pending_items = {pending_items, elem_item(16'sh0001, 1)};
		pending_items = {pending_items, eof_item()};
		drain();

		// Fill the gallery past capacity: nothing can exceed the top threshold.
		cfg_write(REG_MATCH_THRESHOLD, 16'sh7fff);
		cfg_write(REG_MISS_LIMIT, MISS_SAT);
		for (int i = 0; i < NP + 2; i++) push_noise(2);
		pending_items = {pending_items, eof_item()};
		drain();
		// Evict everything: two frames without hits at limit zero.
		cfg_write(REG_MISS_LIMIT, 16'd0);
		pending_items = {pending_items, eof_item()};
		pending_items = {pending_items, eof_item()};
		drain();

		cfg_write(REG_MATCH_THRESHOLD, THRESHOLD_RESET);
		cfg_write(REG_MISS_LIMIT, 16'd3);
		run_random(320, 1);
		cfg_write(REG_MATCH_THRESHOLD, 16'sh8000);
		cfg_write(REG_MISS_LIMIT, 16'd0);
		run_random(300, 0);
		cfg_write(REG_MATCH_THRESHOLD, 16'sd0);
		cfg_write(REG_MISS_LIMIT, 16'd1);
		run_random(300, 0);
		cfg_write(REG_MATCH_THRESHOLD, 16'sd30000);
		cfg_write(REG_MISS_LIMIT, 16'd2);
		run_random(300, 0);
		// Last stretch runs at full rate on both sides.
		cfg_write(REG_MATCH_THRESHOLD, 16'sd20000);
		cfg_write(REG_MISS_LIMIT, 16'd4);
		quiet = 1;
		run_random(250, 0);

		$display("covered %0d transfers in, %0d results: %0d matches, %0d new ids",
			n_accepted, n_res, n_match, n_new);
		$display("gallery overflow hits %0d, evictions %0d, mismatches %0d",
			n_unstored, n_evict, n_err);
		if (n_err == 0) begin
			$display("tb_reid_gallery_matcher_core: clean");
		end else begin
			$display("tb_reid_gallery_matcher_core: errors");
		end
		$finish;
	end
endmodule
